// File: hw/rtl/heading_pd_with_setpoint_ramp_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heading PD controller
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef HEADING_PD_WITH_SETPOINT_RAMP_TOP_MACROS_SVH
`define HEADING_PD_WITH_SETPOINT_RAMP_TOP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define HPR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define HPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/hpr_pkg.sv
// ----------------------------------------------------------------------------
// hpr_pkg
// Types, constants and angle helpers for the heading PD controller.
// ----------------------------------------------------------------------------
package hpr_pkg;

    // Angles are in 1/64 degree.
    localparam logic signed [17:0] HALF_TURN = 18'sd11520;
    localparam logic signed [17:0] FULL_TURN = 18'sd23040;
    localparam int unsigned        PD_SHIFT  = 7;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        IDX_FINAL_HEADING = 3'd0,
        IDX_PROP_GAIN     = 3'd1,
        IDX_DERIV_GAIN    = 3'd2,
        IDX_MAX_STEP      = 3'd3,
        IDX_OUTPUT_LIMIT  = 3'd4,
        IDX_DEADBAND      = 3'd5
    } cfg_idx_t;

    // Wraps an angle into [-180, +180] degrees. Every caller stays within
    // one full turn of that range, so a single correction is enough.
    function automatic logic signed [14:0] wrap_angle(input logic signed [17:0] v);
        logic signed [17:0] t;
        t = v;
        if (v > HALF_TURN)
        begin
            t = v - FULL_TURN;
        end
        else if (v < -HALF_TURN)
        begin
            t = v + FULL_TURN;
        end
        return t[14:0];
    endfunction

endpackage

// File: hw/rtl/heading_pd_with_setpoint_ramp_top.sv
// ----------------------------------------------------------------------------
// heading_pd_with_setpoint_ramp_top
// Heading PD controller with a rate-limited, shortest-path setpoint ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word on the in_* channel is one control tick carrying the
//   measured heading. The block ramps its kept setpoint toward the final
//   heading register, forms the wrapped error and a PD rate command clamped
//   to +-output_limit, zero in the deadband, and returns one result word per
//   input word on the out_* channel: rate_command, arrived and ramped_heading.
//   A word is taken on a rising edge with valid high and stall low.
//   Configuration words arrive on the cfg_* channel, which is always ready;
//   write only while no tick is in flight. Unknown indexes are ignored.
//   The datapath is a four-register pipeline (input register, ramp and error,
//   the two gain multipliers, sum with shift and clamp into the output
//   register), so one word is accepted every cycle while the receiver
//   keeps up.
//   When out_stall holds the result, earlier stages keep filling; in_stall
//   rises only once all four stages hold words.
//   Reset loads the documented register defaults and clears the setpoint,
//   the previous error and all stage valid flags.
// ----------------------------------------------------------------------------
module heading_pd_with_setpoint_ramp_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [14:0]               measured_heading,
    // Output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               rate_command,
    output logic                             arrived,
    output logic signed [14:0]               ramped_heading,
    // Configuration channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hpr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hpr_pkg::*;

    // Configuration registers.
    logic signed [15:0] final_heading_reg;
    logic        [15:0] prop_gain_reg;
    logic        [15:0] deriv_gain_reg;
    logic        [13:0] max_step_reg;
    logic        [14:0] output_limit_reg;
    logic        [13:0] deadband_reg;

    // Controller state.
    logic signed [14:0] setpoint_reg;
    logic signed [14:0] prev_err_reg;

    // Stage valid flags.
    logic s0_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;

    // Stage payloads.
    logic signed [14:0] meas_reg;
    logic signed [14:0] s1_err_reg;
    logic signed [15:0] s1_derr_reg;
    logic signed [14:0] s1_sp_reg;
    logic               s1_arrived_reg;
    logic signed [31:0] s2_pprod_reg;
    logic signed [32:0] s2_dprod_reg;
    logic signed [14:0] s2_sp_reg;
    logic               s2_arrived_reg;
    logic signed [15:0] cmd_reg;
    logic               arrived_reg;
    logic signed [14:0] ramp_reg;

    // Pipeline flow control: a stage may load when it is empty or when its
    // content moves on in the same cycle.
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s0_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s0_free  = !s0_valid_reg || s1_free;

    assign in_stall  = !s0_free;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Stage 1: setpoint ramp, wrapped error, error change and deadband.
    // ------------------------------------------------------------------
    logic signed [14:0] goal;
    logic signed [17:0] goal_w;
    logic signed [17:0] sp_w;
    logic signed [17:0] step_w;
    logic signed [17:0] sp_moved;
    logic signed [14:0] sp_next;
    logic signed [14:0] err_next;
    logic signed [15:0] derr_next;
    logic        [13:0] err_mag;
    logic               arrived_next;

    always_comb
    begin
        goal   = wrap_angle(18'(final_heading_reg));
        goal_w = 18'(goal);
        sp_w   = 18'(setpoint_reg);
        step_w = 18'(signed'({4'd0, max_step_reg}));

        // Move toward the goal the shorter way around; snap when close.
        if (sp_w < goal_w - step_w)
        begin
            if (goal_w - sp_w > HALF_TURN)
            begin
                sp_moved = sp_w - step_w;
            end
            else
            begin
                sp_moved = sp_w + step_w;
            end
        end
        else if (sp_w > goal_w + step_w)
        begin
            if (sp_w - goal_w > HALF_TURN)
            begin
                sp_moved = sp_w + step_w;
            end
            else
            begin
                sp_moved = sp_w - step_w;
            end
        end
        else
        begin
            sp_moved = goal_w;
        end
        sp_next = wrap_angle(sp_moved);

        err_next  = wrap_angle(18'(sp_next) - 18'(meas_reg));
        derr_next = 16'(err_next) - 16'(prev_err_reg);

        if (err_next < 0)
        begin
            err_mag = 14'(-err_next);
        end
        else
        begin
            err_mag = 14'(err_next);
        end
        arrived_next = err_mag < deadband_reg;
    end

    // ------------------------------------------------------------------
    // Stage 2: the two gain products.
    // ------------------------------------------------------------------
    logic signed [31:0] pprod_next;
    logic signed [32:0] dprod_next;

    always_comb
    begin
        pprod_next = signed'({1'b0, prop_gain_reg}) * s1_err_reg;
        dprod_next = signed'({1'b0, deriv_gain_reg}) * s1_derr_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: sum, floor shift, symmetric clamp and deadband override.
    // ------------------------------------------------------------------
    logic signed [33:0] pd_sum;
    logic signed [26:0] pd_shifted;
    logic signed [26:0] lim_pos;
    logic signed [26:0] lim_neg;
    logic signed [15:0] cmd_next;

    always_comb
    begin
        pd_sum     = 34'(s2_pprod_reg) + 34'(s2_dprod_reg);
        pd_shifted = 27'(pd_sum >>> PD_SHIFT);
        lim_pos    = 27'(signed'({1'b0, output_limit_reg}));
        lim_neg    = -lim_pos;
        if (s2_arrived_reg)
        begin
            cmd_next = '0;
        end
        else if (pd_shifted > lim_pos)
        begin
            cmd_next = lim_pos[15:0];
        end
        else if (pd_shifted < lim_neg)
        begin
            cmd_next = lim_neg[15:0];
        end
        else
        begin
            cmd_next = pd_shifted[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            final_heading_reg <= 16'sd0;
            prop_gain_reg     <= 16'd3932;
            deriv_gain_reg    <= 16'd6554;
            max_step_reg      <= 14'd640;
            output_limit_reg  <= 15'd29491;
            deadband_reg      <= 14'd64;
            setpoint_reg      <= '0;
            prev_err_reg      <= '0;
            s0_valid_reg      <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    IDX_FINAL_HEADING: final_heading_reg <= signed'(cfg_data);
                    IDX_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                    IDX_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                    IDX_MAX_STEP:      max_step_reg      <= cfg_data[13:0];
                    IDX_OUTPUT_LIMIT:  output_limit_reg  <= cfg_data[14:0];
                    IDX_DEADBAND:      deadband_reg      <= cfg_data[13:0];
                    default:           ;
                endcase
            end

            // The tick takes effect on the state as it enters stage 1.
            if (s0_valid_reg && s1_free)
            begin
                setpoint_reg <= sp_next;
                prev_err_reg <= err_next;
            end

            if (s0_free)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s0_free)
        begin
            meas_reg <= measured_heading;
        end
        if (s1_free)
        begin
            s1_err_reg     <= err_next;
            s1_derr_reg    <= derr_next;
            s1_sp_reg      <= sp_next;
            s1_arrived_reg <= arrived_next;
        end
        if (s2_free)
        begin
            s2_pprod_reg   <= pprod_next;
            s2_dprod_reg   <= dprod_next;
            s2_sp_reg      <= s1_sp_reg;
            s2_arrived_reg <= s1_arrived_reg;
        end
        if (out_free)
        begin
            cmd_reg     <= cmd_next;
            arrived_reg <= s2_arrived_reg;
            ramp_reg    <= s2_sp_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign rate_command   = cmd_reg;
    assign arrived        = arrived_reg;
    assign ramped_heading = ramp_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    logic sp_in_range;
    logic err_in_range;
    logic out_arrived;
    logic cmd_is_zero;
    logic pipe_full;
    logic tick_moves;
    logic state_in_s1;

    assign sp_in_range  = (18'(setpoint_reg) <= HALF_TURN) && (18'(setpoint_reg) >= -HALF_TURN);
    assign err_in_range = (18'(prev_err_reg) <= HALF_TURN) && (18'(prev_err_reg) >= -HALF_TURN);
    assign out_arrived  = out_valid_reg && arrived_reg;
    assign cmd_is_zero  = (cmd_reg == 16'sd0);
    assign pipe_full    = s0_valid_reg && s1_valid_reg && s2_valid_reg && out_valid_reg
                          && out_stall;
    assign tick_moves   = s0_valid_reg && s1_free;
    assign state_in_s1  = (setpoint_reg == s1_sp_reg) && (prev_err_reg == s1_err_reg)
                          && s1_valid_reg;

`include "heading_pd_with_setpoint_ramp_top_macros.svh"

    `HPR_ASSERT_SAME(a_sp_range, 1'b1, sp_in_range, "setpoint left the half-turn range")
    `HPR_ASSERT_SAME(a_err_range, 1'b1, err_in_range, "kept error left the half-turn range")
    `HPR_ASSERT_SAME(a_arrived_zero, out_arrived, cmd_is_zero, "arrived word with a command")
    `HPR_ASSERT_SAME(a_stall_full, in_stall, pipe_full, "input stalled with a free stage")
    `HPR_ASSERT_NEXT(a_state_update, tick_moves, state_in_s1, "state and stage 1 disagree")

endmodule
